// ===== rtl/core/ltsp_pkg.sv =====
package ltsp_pkg;

    localparam int RUN_MAX = 3;

    localparam logic [2:0] EV_START  = 3'd0;
    localparam logic [2:0] EV_BYTE   = 3'd1;
    localparam logic [2:0] EV_END    = 3'd2;
    localparam logic [2:0] EV_ENDTLV = 3'd3;
    localparam logic [2:0] EV_CLEAN  = 3'd4;
    localparam logic [2:0] EV_TRUNC  = 3'd5;

    localparam logic [6:0] KIND_END     = 7'd0;
    localparam logic [6:0] KIND_CHASSIS = 7'd1;
    localparam logic [6:0] KIND_PORT    = 7'd2;
    localparam logic [6:0] KIND_TTL     = 7'd3;

    localparam logic [7:0] SUB_CHASSIS_MAC = 8'd4;
    localparam logic [7:0] SUB_PORT_MAC    = 8'd3;
    localparam logic [8:0] MAC_ID_LEN      = 9'd7;
    localparam logic [8:0] TTL_MIN_LEN     = 9'd2;

    typedef enum logic [3:0] {
        PH_HIGH  = 4'b0001,
        PH_LOW   = 4'b0010,
        PH_VALUE = 4'b0100,
        PH_DONE  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [6:0]  tlv_kind;
        logic [8:0]  tlv_len;
        logic [8:0]  value_index;
        logic [7:0]  value_data;
        logic [7:0]  id_subtype;
        logic        id_is_mac;
        logic [15:0] ttl_value;
        logic        ttl_valid;
        logic [15:0] bytes_consumed;
        logic        last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [1:0]                cnt;
        t_out_item [RUN_MAX-1:0]   res;
    } t_run;

endpackage

// ===== rtl/core/ltsp_in_if.sv =====
interface ltsp_in_if
    import ltsp_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ltsp_out_if.sv =====
interface ltsp_out_if
    import ltsp_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ltsp_parse.sv =====
module ltsp_parse
    import ltsp_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_acc,
    input  t_in_item i_item,
    output t_run     o_run
);

    t_phase                r_phase, n_phase, c_phase;
    logic [7:0]            r_hh, n_hh, c_hh;
    logic [6:0]            r_kind, n_kind, c_kind;
    logic [8:0]            r_len, n_len, c_len;
    logic [8:0]            r_pos, n_pos, c_pos;
    logic [7:0]            r_sub, n_sub, c_sub;
    logic [15:0]           r_ttl, n_ttl, c_ttl;
    logic                  r_seen, n_seen, c_seen;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt, c_cnt, w_cnt_inc;
    logic [31:0]           w_cnt32;
    logic [15:0]           w_bytes;
    logic [7:0]            w_b;
    logic                  w_first, w_last;
    logic                  w_closes, w_ttl_tlv, w_mac;
    t_out_item             w_base, w_end, w_tail;
    t_run                  w_run;

    assign w_b     = i_item.data_byte;
    assign w_first = i_item.first_byte;
    assign w_last  = i_item.last_byte;

    // first byte of a pdu sees the reset state
    assign c_phase = w_first ? PH_HIGH : r_phase;
    assign c_hh    = w_first ? 8'd0 : r_hh;
    assign c_kind  = w_first ? 7'd0 : r_kind;
    assign c_len   = w_first ? 9'd0 : r_len;
    assign c_pos   = w_first ? 9'd0 : r_pos;
    assign c_sub   = w_first ? 8'd0 : r_sub;
    assign c_ttl   = w_first ? 16'd0 : r_ttl;
    assign c_seen  = w_first ? 1'b0 : r_seen;
    assign c_cnt   = w_first ? '0 : r_cnt;

    assign w_cnt_inc = (c_cnt == '1) ? c_cnt : c_cnt + {{(COUNT_BITS-1){1'b0}}, 1'b1};

    assign w_ttl_tlv = (n_kind == KIND_TTL) && (n_len >= TTL_MIN_LEN);
    assign w_mac     = (n_len == MAC_ID_LEN) &&
                       (((n_kind == KIND_CHASSIS) && (n_sub == SUB_CHASSIS_MAC)) ||
                        ((n_kind == KIND_PORT) && (n_sub == SUB_PORT_MAC)));

    always_comb begin
        w_closes = 1'b0;
        case (c_phase)
            PH_LOW:   w_closes = (c_hh[7:1] != KIND_END) && ({c_hh[0], w_b} == 9'd0);
            PH_VALUE: w_closes = ({1'b0, c_pos} + 10'd1) >= {1'b0, c_len};
            default:  w_closes = 1'b0;
        endcase
    end

    always_comb begin
        n_phase = c_phase;
        n_hh    = c_hh;
        n_kind  = c_kind;
        n_len   = c_len;
        n_pos   = c_pos;
        n_sub   = c_sub;
        n_ttl   = c_ttl;
        n_cnt   = c_cnt;
        case (c_phase)
            PH_HIGH: begin
                if (w_last) begin
                    n_phase = PH_DONE;
                end else begin
                    n_hh    = w_b;
                    n_cnt   = w_cnt_inc;
                    n_phase = PH_LOW;
                end
            end
            PH_LOW: begin
                n_cnt  = w_cnt_inc;
                n_kind = c_hh[7:1];
                n_len  = {c_hh[0], w_b};
                n_pos  = 9'd0;
                n_sub  = 8'd0;
                if (c_hh[7:1] == KIND_END || w_last) begin
                    n_phase = PH_DONE;
                end else if (w_closes) begin
                    n_phase = PH_HIGH;
                end else begin
                    n_phase = PH_VALUE;
                end
            end
            PH_VALUE: begin
                n_cnt = w_cnt_inc;
                if (c_pos == 9'd0) begin
                    n_sub = w_b;
                end
                if (c_kind == KIND_TTL && c_len >= TTL_MIN_LEN) begin
                    if (c_pos == 9'd0) begin
                        n_ttl = {w_b, c_ttl[7:0]};
                    end else if (c_pos == 9'd1) begin
                        n_ttl = {c_ttl[15:8], w_b};
                    end
                end
                if (w_closes) begin
                    n_pos   = 9'd0;
                    n_phase = w_last ? PH_DONE : PH_HIGH;
                end else begin
                    n_pos   = c_pos + 9'd1;
                    n_phase = w_last ? PH_DONE : PH_VALUE;
                end
            end
            default: begin
                n_phase = c_phase;
            end
        endcase
    end

    assign n_seen = c_seen | (w_closes & w_ttl_tlv);

    assign w_cnt32 = 32'(n_cnt);
    assign w_bytes = (|w_cnt32[31:16]) ? 16'hFFFF : w_cnt32[15:0];

    always_comb begin
        w_base                = '0;
        w_base.tlv_kind       = n_kind;
        w_base.tlv_len        = n_len;
        w_base.ttl_value      = n_ttl;
        w_base.ttl_valid      = c_seen;
        w_base.bytes_consumed = w_bytes;

        w_end            = w_base;
        w_end.event_res  = EV_END;
        w_end.id_subtype = n_sub;
        w_end.id_is_mac  = w_mac;
        w_end.ttl_valid  = n_seen;

        w_tail           = w_base;
        w_tail.ttl_valid = n_seen;
        w_tail.event_res = w_closes ? EV_CLEAN : EV_TRUNC;

        w_run.cnt = 2'd0;
        for (int i = 0; i < RUN_MAX; i++) begin
            w_run.res[i] = w_base;
        end

        case (c_phase)
            PH_HIGH: begin
                if (w_last) begin
                    w_run.res[0]           = w_tail;
                    w_run.res[0].event_res = (c_cnt != '0) ? EV_CLEAN : EV_TRUNC;
                    w_run.cnt              = 2'd1;
                end
            end
            PH_LOW: begin
                if (c_hh[7:1] == KIND_END) begin
                    w_run.res[0].event_res = EV_ENDTLV;
                    w_run.cnt              = 2'd1;
                end else begin
                    w_run.res[0].event_res = EV_START;
                    if (w_closes) begin
                        w_run.res[1] = w_end;
                        w_run.res[2] = w_tail;
                        w_run.cnt    = w_last ? 2'd3 : 2'd2;
                    end else begin
                        w_run.res[1] = w_tail;
                        w_run.cnt    = w_last ? 2'd2 : 2'd1;
                    end
                end
            end
            PH_VALUE: begin
                w_run.res[0].event_res   = EV_BYTE;
                w_run.res[0].value_index = c_pos;
                w_run.res[0].value_data  = w_b;
                if (w_closes) begin
                    w_run.res[1] = w_end;
                    w_run.res[2] = w_tail;
                    w_run.cnt    = w_last ? 2'd3 : 2'd2;
                end else begin
                    w_run.res[1] = w_tail;
                    w_run.cnt    = w_last ? 2'd2 : 2'd1;
                end
            end
            default: begin
                w_run.cnt = 2'd0;
            end
        endcase

        for (int i = 0; i < RUN_MAX; i++) begin
            w_run.res[i].last_of_run = (2'(i) == (w_run.cnt - 2'd1));
        end
    end

    assign o_run = w_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HIGH;
            r_hh    <= 8'd0;
            r_kind  <= 7'd0;
            r_len   <= 9'd0;
            r_pos   <= 9'd0;
            r_sub   <= 8'd0;
            r_ttl   <= 16'd0;
            r_seen  <= 1'b0;
            r_cnt   <= '0;
        end else if (i_acc) begin
            r_phase <= n_phase;
            r_hh    <= n_hh;
            r_kind  <= n_kind;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_sub   <= n_sub;
            r_ttl   <= n_ttl;
            r_seen  <= n_seen;
            r_cnt   <= n_cnt;
        end
    end

    // a value byte never sits past the declared length
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_VALUE |-> r_pos < r_len)
        else $error("value position beyond tlv length");

    // an end tlv header always closes the pdu
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && c_phase == PH_LOW && c_hh[7:1] == KIND_END |=> r_phase == PH_DONE)
        else $error("end tlv did not close the pdu");

    // once valid the ttl flag holds until a new pdu starts
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen && !(i_acc && w_first) |=> r_seen)
        else $error("ttl flag dropped inside a pdu");

endmodule

// ===== rtl/core/lldp_tlv_stream_parser.sv =====
// results: an accepted byte's results are registered and then presented in order
// throughput: one byte per cycle while each byte gives at most one result and the
// receiver takes each result; a byte giving more results (up to three) holds the input
// until the single output register has drained the run, one transfer a cycle while ready is high
// reset: synchronous active-low i_rst_n clears parse state and empties the output
module lldp_tlv_stream_parser
    import ltsp_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ltsp_in_if.sink           i_in,
    ltsp_out_if.source        o_out
);

    t_run                     w_run;
    t_out_item [RUN_MAX-1:0]  r_res;
    logic [1:0]               r_run_cnt;
    logic [1:0]               r_idx;
    logic                     w_take, w_done, w_acc;

    assign w_take = o_out.valid && o_out.ready;
    assign w_done = w_take && (r_idx == (r_run_cnt - 2'd1));

    assign i_in.ready  = (r_run_cnt == 2'd0) || w_done;
    assign w_acc       = i_in.valid && i_in.ready;
    assign o_out.valid = (r_run_cnt != 2'd0);
    assign o_out.data  = r_res[r_idx];

    ltsp_parse #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_item  (i_in.data),
        .o_run   (w_run)
    );

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_res <= w_run.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_cnt <= 2'd0;
            r_idx     <= 2'd0;
        end else if (w_acc) begin
            r_run_cnt <= w_run.cnt;
            r_idx     <= 2'd0;
        end else if (w_done) begin
            r_run_cnt <= 2'd0;
            r_idx     <= 2'd0;
        end else if (w_take) begin
            r_idx     <= r_idx + 2'd1;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_cnt != 2'd0 |-> r_idx < r_run_cnt)
        else $error("output index outside the run");

    // last flag on the output matches the sequencer position
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.data.last_of_run == (r_idx == (r_run_cnt - 2'd1)))
        else $error("last of run flag out of step");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_run.cnt != 2'd0 |=> o_out.valid && r_idx == 2'd0)
        else $error("accepted run not presented");

    // every result of one run belongs to the same tlv
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && !w_done |=> $stable(o_out.data.tlv_kind) && $stable(o_out.data.tlv_len))
        else $error("tlv header changed within a run");

endmodule

// ===== sim/lldp_tlv_stream_parser_test.sv =====
module lldp_tlv_stream_parser_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ltsp_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_BYTES = 300;
    localparam int PRINT_MAX = 40;

    typedef logic [7:0] t_byte_q[$];

    class tlv_event_board;
        t_out_item   expected_events[$];
        int          errors;
        t_phase      phase;
        logic [7:0]  header_high;
        logic [6:0]  cur_kind;
        logic [8:0]  cur_len;
        logic [8:0]  value_pos;
        logic [7:0]  subtype_reg;
        logic [15:0] ttl_reg;
        logic        ttl_seen;
        logic [15:0] consumed;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase = PH_HIGH;
            header_high = '0;
            cur_kind = '0;
            cur_len = '0;
            value_pos = '0;
            subtype_reg = '0;
            ttl_reg = '0;
            ttl_seen = 1'b0;
            consumed = '0;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void bump_count();
            if (consumed != 16'hFFFF) begin
                consumed = consumed + 16'd1;
            end
        endfunction

        function void add_event(logic [2:0] ev, logic [8:0] idx, logic [7:0] dat,
                                logic [7:0] sub, logic mac);
            t_out_item r;
            r.event_res = ev;
            r.tlv_kind = cur_kind;
            r.tlv_len = cur_len;
            r.value_index = idx;
            r.value_data = dat;
            r.id_subtype = sub;
            r.id_is_mac = mac;
            r.ttl_value = ttl_reg;
            r.ttl_valid = ttl_seen;
            r.bytes_consumed = consumed;
            r.last_of_run = 1'b0;
            expected_events = {expected_events, r};
        endfunction

        function void add_tlv_end();
            logic mac;
            mac = (cur_len == MAC_ID_LEN) &&
                  ((cur_kind == KIND_CHASSIS && subtype_reg == SUB_CHASSIS_MAC) ||
                   (cur_kind == KIND_PORT && subtype_reg == SUB_PORT_MAC));
            if (cur_kind == KIND_TTL && cur_len >= TTL_MIN_LEN) begin
                ttl_seen = 1'b1;
            end
            add_event(EV_END, '0, '0, subtype_reg, mac);
        endfunction

        function void note_byte(t_in_item it);
            int before_n;
            before_n = expected_events.size();
            if (it.first_byte) begin
                clear();
            end
            case (phase)
                PH_HIGH: begin
                    if (it.last_byte) begin
                        add_event((consumed != 0) ? EV_CLEAN : EV_TRUNC, '0, '0, '0, 1'b0);
                        phase = PH_DONE;
                    end else begin
                        header_high = it.data_byte;
                        bump_count();
                        phase = PH_LOW;
                    end
                end
                PH_LOW: begin
                    bump_count();
                    cur_kind = header_high[7:1];
                    cur_len = {header_high[0], it.data_byte};
                    value_pos = '0;
                    subtype_reg = '0;
                    if (cur_kind == KIND_END) begin
                        add_event(EV_ENDTLV, '0, '0, '0, 1'b0);
                        phase = PH_DONE;
                    end else begin
                        add_event(EV_START, '0, '0, '0, 1'b0);
                        if (cur_len == 0) begin
                            add_tlv_end();
                            phase = PH_HIGH;
                            if (it.last_byte) begin
                                add_event(EV_CLEAN, '0, '0, '0, 1'b0);
                                phase = PH_DONE;
                            end
                        end else begin
                            phase = PH_VALUE;
                            if (it.last_byte) begin
                                add_event(EV_TRUNC, '0, '0, '0, 1'b0);
                                phase = PH_DONE;
                            end
                        end
                    end
                end
                PH_VALUE: begin
                    bump_count();
                    if (value_pos == 0) begin
                        subtype_reg = it.data_byte;
                    end
                    if (cur_kind == KIND_TTL && cur_len >= TTL_MIN_LEN) begin
                        if (value_pos == 0) begin
                            ttl_reg[15:8] = it.data_byte;
                        end else if (value_pos == 1) begin
                            ttl_reg[7:0] = it.data_byte;
                        end
                    end
                    add_event(EV_BYTE, value_pos, it.data_byte, '0, 1'b0);
                    if (int'(value_pos) + 1 >= int'(cur_len)) begin
                        add_tlv_end();
                        phase = PH_HIGH;
                        value_pos = '0;
                        if (it.last_byte) begin
                            add_event(EV_CLEAN, '0, '0, '0, 1'b0);
                            phase = PH_DONE;
                        end
                    end else begin
                        value_pos = value_pos + 9'd1;
                        if (it.last_byte) begin
                            add_event(EV_TRUNC, '0, '0, '0, 1'b0);
                            phase = PH_DONE;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (expected_events.size() > before_n) begin
                expected_events[expected_events.size() - 1].last_of_run = 1'b1;
            end
        endfunction

        function void field_check(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= PRINT_MAX) begin
                    $display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
                end
            end
        endfunction

        function void check_event(t_out_item got);
            t_out_item want;
            if (expected_events.size() == 0) begin
                errors++;
                if (errors <= PRINT_MAX) begin
                    $display("%0t unexpected result expected none actual event %0d kind %0d",
                             $time, got.event_res, got.tlv_kind);
                end
            end else begin
                want = expected_events.pop_front();
                field_check("event_res", want.event_res, got.event_res);
                field_check("tlv_kind", want.tlv_kind, got.tlv_kind);
                field_check("tlv_len", want.tlv_len, got.tlv_len);
                field_check("value_index", want.value_index, got.value_index);
                field_check("value_data", want.value_data, got.value_data);
                field_check("id_subtype", want.id_subtype, got.id_subtype);
                field_check("id_is_mac", want.id_is_mac, got.id_is_mac);
                field_check("ttl_value", want.ttl_value, got.ttl_value);
                field_check("ttl_valid", want.ttl_valid, got.ttl_valid);
                field_check("bytes_consumed", want.bytes_consumed, got.bytes_consumed);
                field_check("last_of_run", want.last_of_run, got.last_of_run);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ltsp_in_if  in_if();
    ltsp_out_if out_if();

    tlv_event_board board = new();

    int burst_left;
    bit hold_req;
    int pdu_bytes;
    int idle_cycles = 0;

    lldp_tlv_stream_parser DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic void add_to_seq(ref t_byte_q q, input logic [7:0] b);
        q = {q, b};
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        t_in_item it;
        int gap;
        it.data_byte = b;
        it.first_byte = first;
        it.last_byte = last;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        in_if.valid <= 1'b1;
        in_if.data <= it;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        board.note_byte(it);
    endtask

    task automatic send_seq(input t_byte_q seq, input bit with_first, input bit with_last);
        for (int i = 0; i < seq.size(); i++) begin
            send_byte(seq[i], with_first && i == 0, with_last && i == seq.size() - 1);
        end
        pdu_bytes += seq.size();
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    task automatic add_tlv(ref t_byte_q seq);
        int pick;
        logic [6:0] kind;
        logic [8:0] len;
        logic [7:0] sub;
        pick = $urandom_range(0, 29);
        sub = $urandom;
        if (pick < 6) begin
            kind = KIND_CHASSIS;
            len = ($urandom_range(0, 1) == 1) ? MAC_ID_LEN : 9'($urandom_range(0, 12));
            if ($urandom_range(0, 2) != 0) sub = ($urandom_range(0, 3) == 0) ? SUB_PORT_MAC
                                                                             : SUB_CHASSIS_MAC;
        end else if (pick < 12) begin
            kind = KIND_PORT;
            len = ($urandom_range(0, 1) == 1) ? MAC_ID_LEN : 9'($urandom_range(0, 12));
            if ($urandom_range(0, 2) != 0) sub = ($urandom_range(0, 3) == 0) ? SUB_CHASSIS_MAC
                                                                             : SUB_PORT_MAC;
        end else if (pick < 18) begin
            kind = KIND_TTL;
            len = 9'($urandom_range(0, 4));
        end else if (pick == 18) begin
            kind = 7'($urandom_range(1, 127));
            len = 9'($urandom_range(256, 300));
        end else begin
            kind = 7'($urandom_range(1, 127));
            len = 9'($urandom_range(0, 16));
        end
        add_to_seq(seq, {kind, len[8]});
        add_to_seq(seq, len[7:0]);
        for (int i = 0; i < len; i++) begin
            add_to_seq(seq, (i == 0) ? sub : 8'($urandom));
        end
    endtask

    task automatic random_pdu();
        t_byte_q seq;
        int ntlv;
        int ending;
        int cut;
        bit do_last;
        ntlv = $urandom_range(0, 5);
        repeat (ntlv) add_tlv(seq);
        ending = $urandom_range(0, 9);
        do_last = 1'b1;
        case (ending)
            4, 5: begin
                add_to_seq(seq, {KIND_END, 1'($urandom)});
                add_to_seq(seq, 8'($urandom));
                do_last = $urandom_range(0, 1);
            end
            6: begin
                if (seq.size() > 0) begin
                    cut = $urandom_range(1, seq.size());
                    while (seq.size() > cut) void'(seq.pop_back());
                end
            end
            7: add_to_seq(seq, 8'($urandom));
            8: do_last = 1'b0;
            9: begin
                if (seq.size() > 0) seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom);
                do_last = $urandom_range(0, 1);
            end
            default: begin
            end
        endcase
        if (seq.size() == 0) begin
            add_to_seq(seq, 8'($urandom));
        end
        send_seq(seq, 1'b1, do_last);
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'($urandom));
        end
    endtask

    // receiver: changing stall patterns, plus one long hold-off on request
    initial begin : receiver
        int mode;
        int left;
        int cyc;
        logic rdy;
        bit hold_done;
        mode = 0;
        left = 0;
        cyc = 0;
        hold_done = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(16, 96);
                end
                left--;
                cyc++;
                case (mode)
                    0: rdy = 1'b1;
                    1: rdy = $urandom_range(0, 1);
                    2: rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = (cyc % 5) != 4;
                endcase
                out_if.ready <= rdy;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            board.check_event(out_if.data);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t timeout, %0d transfers still expected", $time, board.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_byte_q seq;
        int pdu_n;
        burst_left = 0;
        hold_req = 1'b0;
        pdu_bytes = 0;
        pdu_n = 0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // chassis mac id, ttl 0xffff, empty type 127, end tlv with length bit set
        seq = {8'h02, 8'h07, 8'h04, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'hFF,
               8'h06, 8'h02, 8'hFF, 8'hFF, 8'hFE, 8'h00, 8'h01, 8'hFF};
        send_seq(seq, 1'b1, 1'b0);
        send_byte(8'h5A, 1'b0, 1'b1);
        // lone header byte with nothing consumed
        send_byte(8'h00, 1'b1, 1'b1);
        // port id cut inside the value
        seq = {8'h04, 8'h07, 8'h03, 8'hAB};
        send_seq(seq, 1'b1, 1'b1);
        // ttl cut after its first byte
        seq = {8'h06, 8'h02, 8'hC3};
        send_seq(seq, 1'b1, 1'b1);
        // empty value then a lone trailing header byte
        seq = {8'h08, 8'h00, 8'h0A};
        send_seq(seq, 1'b1, 1'b1);
        // end tlv on the last byte
        seq = {8'h00, 8'h05};
        send_seq(seq, 1'b1, 1'b1);

        pdu_bytes = 0;
        while (pdu_bytes < RANDOM_BYTES) begin
            if (pdu_n == 0) begin
                hold_req = 1'b1;
            end
            if (pdu_n == 12) begin
                drain_results();
            end
            random_pdu();
            pdu_n++;
        end

        drain_results();

        in_if.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
